// ===== rtl/mtg_pkg.sv =====
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int KEY_DEPTH     = 624;
    localparam int STATE_AW      = 10;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] KEY_MULT_A   = 32'd1664525;
    localparam logic [31:0] KEY_MULT_B   = 32'd1566083941;
    localparam logic [31:0] KEY_BASE     = 32'd19650218;

    // request function codes
    localparam logic [1:0] FUNC_GEN  = 2'd0;
    localparam logic [1:0] FUNC_SEED = 2'd1;
    localparam logic [1:0] FUNC_KEY  = 2'd2;

    // write port of the state memory
    typedef struct packed {
        logic                we;
        logic [STATE_AW-1:0] addr;
        logic [31:0]         data;
    } t_state_wr;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in ^ (y_in >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mix_pair(input logic [31:0] hi_src,
                                             input logic [31:0] lo_src,
                                             input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = (hi_src & HIGH_BIT) | (lo_src & LOW_BITS);
        r = far ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mtg_if.sv =====
interface mtg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] seed_word;
    logic        key_last;

    modport source (output valid, output func, output seed_word, output key_last,
                    input ready);
    modport sink (input valid, input func, input seed_word, input key_last,
                  output ready);
endinterface

interface mtg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ===== rtl/mtg_state_ram.sv =====
module mtg_state_ram (
    input  logic                         i_clk,
    input  mtg_pkg::t_state_wr           i_wr,
    input  logic                         i_rd_en,
    input  logic [mtg_pkg::STATE_AW-1:0] i_rd_addr_a,
    input  logic [mtg_pkg::STATE_AW-1:0] i_rd_addr_b,
    output logic [31:0]                  o_rd_data_a,
    output logic [31:0]                  o_rd_data_b
);

    logic [31:0] r_mem [mtg_pkg::STATE_WORDS];

    // write one word
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read two words, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

// ===== rtl/mtg_key_ram.sv =====
module mtg_key_ram #(
    parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH,
    parameter int AW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    logic [31:0] r_mem [KEY_DEPTH];

    // store key word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read key word, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/mt19937_generator.sv =====
// MT19937 generator. Requests: generate (returns one tempered word), scalar
// seed, and key word (the word marked last runs array seeding). A generate
// reads the state word and tempers it into the output register; when the
// 624-word state is used up it first twists the whole state in place, one
// word per read state and write state pair. A scalar seed writes one word per
// multiply/write pair; array seeding then adds max(624, key length) and then
// 623 key-mixing read/write pairs. Key words are stored as they are accepted.
// The block takes one request at a time; a finished word waits in the output
// register while the next request is accepted. Generate before any seeding
// returns undefined words.
module mt19937_generator #(
    parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtg_req_if.sink       i_req,
    mtg_rsp_if.source     o_rsp
);

    localparam int AW   = mtg_pkg::STATE_AW;
    localparam int JW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW  = $clog2(KEY_DEPTH + 1);
    localparam int MAXK = (KEY_DEPTH > mtg_pkg::STATE_WORDS) ? KEY_DEPTH
                                                               : mtg_pkg::STATE_WORDS;
    localparam int CW   = $clog2(MAXK + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TW_INIT = 4'd1;
    localparam logic [3:0] S_TW_RD   = 4'd2;
    localparam logic [3:0] S_TW_WR   = 4'd3;
    localparam logic [3:0] S_GEN_RD  = 4'd4;
    localparam logic [3:0] S_GEN_OUT = 4'd5;
    localparam logic [3:0] S_SS_INIT = 4'd6;
    localparam logic [3:0] S_SS_MUL  = 4'd7;
    localparam logic [3:0] S_SS_WR   = 4'd8;
    localparam logic [3:0] S_K1_RD   = 4'd9;
    localparam logic [3:0] S_K1_WR   = 4'd10;
    localparam logic [3:0] S_K2_RD   = 4'd11;
    localparam logic [3:0] S_K2_WR   = 4'd12;
    localparam logic [3:0] S_K_FIN   = 4'd13;

    localparam logic [AW-1:0] LAST_IDX = AW'(mtg_pkg::STATE_WORDS - 1);

    logic [3:0]     r_state, n_state;
    logic [AW-1:0]  r_pos, n_pos;
    logic [AW-1:0]  r_idx, n_idx;
    logic [JW-1:0]  r_j, n_j;
    logic [KCW-1:0] r_key_count, n_key_count;
    logic [KCW-1:0] r_len, n_len;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_by_key, n_by_key;
    logic [31:0]    r_seed, n_seed;
    logic [31:0]    r_prev, n_prev;
    logic [31:0]    r_cur, n_cur;
    logic [31:0]    r_prod, n_prod;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_out_word, n_out_word;

    mtg_pkg::t_state_wr st_wr;
    logic               st_rd_en;
    logic [AW-1:0]      st_addr_a, st_addr_b;
    logic [31:0]        st_data_a, st_data_b;
    logic               key_we, key_rd_en;
    logic [31:0]        key_data;

    logic [AW:0]    far_sum;
    logic [AW-1:0]  far_idx, next_idx, wrap_idx;
    logic [31:0]    mult_a, mult_b, val;
    logic [63:0]    mult_full;
    logic           accept;
    logic [KCW-1:0] stored_len;

    mtg_state_ram u_state_ram (
        .i_clk       (i_clk),
        .i_wr        (st_wr),
        .i_rd_en     (st_rd_en),
        .i_rd_addr_a (st_addr_a),
        .i_rd_addr_b (st_addr_b),
        .o_rd_data_a (st_data_a),
        .o_rd_data_b (st_data_b)
    );

    mtg_key_ram #(.KEY_DEPTH(KEY_DEPTH), .AW(JW)) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (r_key_count[JW-1:0]),
        .i_wr_data (i_req.seed_word),
        .i_rd_en   (key_rd_en),
        .i_rd_addr (r_j),
        .o_rd_data (key_data)
    );

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.random_word = r_out_word;

    // twist neighbor indexes
    assign far_sum  = {1'b0, r_idx} + (AW + 1)'(mtg_pkg::MIDDLE_OFFSET);
    assign far_idx  = (far_sum >= (AW + 1)'(mtg_pkg::STATE_WORDS))
                    ? AW'(far_sum - (AW + 1)'(mtg_pkg::STATE_WORDS)) : far_sum[AW-1:0];
    assign next_idx = (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
    assign wrap_idx = (r_idx == LAST_IDX) ? AW'(1) : r_idx + AW'(1);

    // shared multiplier, product registered
    assign mult_a = r_prev ^ (r_prev >> 30);
    always_comb begin
        unique case (r_state)
            S_K1_RD: mult_b = mtg_pkg::KEY_MULT_A;
            S_K2_RD: mult_b = mtg_pkg::KEY_MULT_B;
            default: mult_b = mtg_pkg::SEED_MULT;
        endcase
    end
    assign mult_full = mult_a * mult_b;

    assign stored_len = (r_key_count < KCW'(KEY_DEPTH)) ? r_key_count + KCW'(1)
                                                         : r_key_count;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_j         = r_j;
        n_key_count = r_key_count;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_by_key    = r_by_key;
        n_seed      = r_seed;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        st_wr       = '0;
        st_rd_en    = 1'b0;
        st_addr_a   = r_idx;
        st_addr_b   = far_idx;
        key_we      = 1'b0;
        key_rd_en   = 1'b0;
        val         = '0;

        // drop the result once taken
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.func)
                        mtg_pkg::FUNC_GEN: begin
                            n_idx   = '0;
                            n_state = (r_pos >= AW'(mtg_pkg::STATE_WORDS)) ? S_TW_INIT
                                                                            : S_GEN_RD;
                        end
                        mtg_pkg::FUNC_SEED: begin
                            n_seed   = i_req.seed_word;
                            n_by_key = 1'b0;
                            n_state  = S_SS_INIT;
                        end
                        mtg_pkg::FUNC_KEY: begin
                            if (r_key_count < KCW'(KEY_DEPTH)) begin
                                key_we      = 1'b1;
                                n_key_count = r_key_count + KCW'(1);
                            end
                            if (i_req.key_last) begin
                                n_len       = stored_len;
                                n_key_count = '0;
                                n_seed      = mtg_pkg::KEY_BASE;
                                n_by_key    = 1'b1;
                                n_state     = S_SS_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // fetch word 0 before the twist
            S_TW_INIT: begin
                st_rd_en  = 1'b1;
                st_addr_a = '0;
                n_state   = S_TW_RD;
            end
            S_TW_RD: begin
                if (r_idx == '0) begin
                    n_cur = st_data_a;
                end
                st_rd_en  = 1'b1;
                st_addr_a = next_idx;
                n_state   = S_TW_WR;
            end
            S_TW_WR: begin
                st_wr.we   = 1'b1;
                st_wr.addr = r_idx;
                st_wr.data = mtg_pkg::mix_pair(r_cur, st_data_a, st_data_b);
                n_cur      = st_data_a;
                n_idx      = next_idx;
                if (r_idx == LAST_IDX) begin
                    n_pos   = '0;
                    n_state = S_GEN_RD;
                end else begin
                    n_state = S_TW_RD;
                end
            end
            S_GEN_RD: begin
                st_rd_en  = 1'b1;
                st_addr_a = r_pos;
                n_state   = S_GEN_OUT;
            end
            // hold until the output register is free
            S_GEN_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = mtg_pkg::temper(st_data_a);
                    n_pos       = r_pos + AW'(1);
                    n_state     = S_IDLE;
                end
            end
            S_SS_INIT: begin
                st_wr.we   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = r_seed;
                n_prev     = r_seed;
                n_idx      = AW'(1);
                n_state    = S_SS_MUL;
            end
            S_SS_MUL: begin
                n_prod  = mult_full[31:0];
                n_state = S_SS_WR;
            end
            S_SS_WR: begin
                val        = r_prod + 32'(r_idx);
                st_wr.we   = 1'b1;
                st_wr.addr = r_idx;
                st_wr.data = val;
                n_prev     = val;
                n_idx      = r_idx + AW'(1);
                if (r_idx == LAST_IDX) begin
                    n_pos = AW'(mtg_pkg::STATE_WORDS);
                    if (r_by_key) begin
                        // key mixing starts at word 1, with word 0 as the previous value
                        n_prev  = r_seed;
                        n_idx   = AW'(1);
                        n_j     = '0;
                        n_cnt   = (r_len > KCW'(mtg_pkg::STATE_WORDS)) ? CW'(r_len)
                                                                       : CW'(mtg_pkg::STATE_WORDS);
                        n_state = S_K1_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SS_MUL;
                end
            end
            // mix key words into the state
            S_K1_RD: begin
                st_rd_en  = 1'b1;
                key_rd_en = 1'b1;
                n_prod    = mult_full[31:0];
                n_state   = S_K1_WR;
            end
            S_K1_WR: begin
                val        = (st_data_a ^ r_prod) + key_data + 32'(r_j);
                st_wr.we   = 1'b1;
                st_wr.addr = r_idx;
                st_wr.data = val;
                n_prev     = val;
                n_idx      = wrap_idx;
                n_j        = ((KCW'(r_j) + KCW'(1)) >= r_len) ? '0 : r_j + JW'(1);
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(mtg_pkg::STATE_WORDS - 1);
                    n_state = S_K2_RD;
                end else begin
                    n_state = S_K1_RD;
                end
            end
            S_K2_RD: begin
                st_rd_en = 1'b1;
                n_prod   = mult_full[31:0];
                n_state  = S_K2_WR;
            end
            S_K2_WR: begin
                val        = (st_data_a ^ r_prod) - 32'(r_idx);
                st_wr.we   = 1'b1;
                st_wr.addr = r_idx;
                st_wr.data = val;
                n_prev     = val;
                n_idx      = wrap_idx;
                n_cnt      = r_cnt - CW'(1);
                n_state    = (r_cnt == CW'(1)) ? S_K_FIN : S_K2_RD;
            end
            S_K_FIN: begin
                st_wr.we   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = mtg_pkg::HIGH_BIT;
                n_pos      = AW'(mtg_pkg::STATE_WORDS);
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= AW'(mtg_pkg::STATE_WORDS);
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_key_count <= n_key_count;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_len      <= n_len;
        r_cnt      <= n_cnt;
        r_by_key   <= n_by_key;
        r_seed     <= n_seed;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_prod     <= n_prod;
        r_out_word <= n_out_word;
    end

endmodule

// ===== rtl/mtg_checker.sv =====
module mtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [1:0]  i_req_func,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_word
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_word))
        else $error("result dropped or changed while stalled");

    // no result right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // a generate request keeps the block busy for the next cycle
    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_func == mtg_pkg::FUNC_GEN |=> !i_req_ready)
        else $error("request taken during generate");

    // a scalar seed keeps the block busy
    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_func == mtg_pkg::FUNC_SEED |=> !i_req_ready)
        else $error("request taken during seeding");

endmodule

bind mt19937_generator mtg_checker u_mtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_func  (i_req.func),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_word  (o_rsp.random_word)
);
